/* hdl/assert_macros.svh */
// Assertion helpers shared by the tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge while out of reset.
`define CILT_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define CILT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/cilt_pkg.sv */
package cilt_pkg;

    localparam int NEST_DEPTH = 8;
    localparam int SIZE_WIDTH = 16;

    localparam int LVL_W  = $clog2(NEST_DEPTH + 1);
    localparam int IDX_W  = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
    localparam int CNT_W  = 9;
    localparam int SKIP_W = 8;
    localparam int ITEM_SIZE_W = 16;

    localparam logic [SIZE_WIDTH-1:0] SIZE_MAX = '1;

    // Major types
    localparam logic [2:0] MT_UINT  = 3'd0;
    localparam logic [2:0] MT_NINT  = 3'd1;
    localparam logic [2:0] MT_BSTR  = 3'd2;
    localparam logic [2:0] MT_TSTR  = 3'd3;
    localparam logic [2:0] MT_ARRAY = 3'd4;
    localparam logic [2:0] MT_MAP   = 3'd5;

    // Additional info thresholds
    localparam logic [4:0] AI_ONE_BYTE = 5'd24;
    localparam logic [4:0] AI_EIGHT_BYTE = 5'd27;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_SKIP   = 2'd1,
        PH_LEN    = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        PK_STRING = 2'd0,
        PK_ARRAY  = 2'd1,
        PK_MAP    = 2'd2
    } pend_kind_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ADDL = 2'd1,
        ST_TAG  = 2'd2,
        ST_DEEP = 2'd3
    } status_t;

    typedef struct packed {
        logic             elem_done;
        logic             push;
        logic [CNT_W-1:0] push_cnt;
        logic             clear;
    } stk_cmd_t;

    typedef struct packed {
        logic full;
        logic top_done;
    } stk_stat_t;

endpackage

/* hdl/cilt_stack.sv */
`include "assert_macros.svh"

module cilt_stack (
    input  logic                aclk,
    input  logic                aresetn,
    input  cilt_pkg::stk_cmd_t  cmd,
    output cilt_pkg::stk_stat_t stat
);

    logic [cilt_pkg::LVL_W-1:0] lvl_reg;
    logic [cilt_pkg::LVL_W-1:0] lvl_next;
    logic [cilt_pkg::CNT_W-1:0] rem_reg  [cilt_pkg::NEST_DEPTH];
    logic [cilt_pkg::CNT_W-1:0] rem_next [cilt_pkg::NEST_DEPTH];

    logic                       found;
    logic [cilt_pkg::IDX_W-1:0] tgt;

    // Innermost open level that survives a completion: the cascade pops every
    // level above it that was waiting on its last element.
    always_comb begin
        found = 1'b0;
        tgt   = '0;
        for (int j = 0; j < cilt_pkg::NEST_DEPTH; j++) begin
            if (cilt_pkg::LVL_W'(j) < lvl_reg && rem_reg[j] != cilt_pkg::CNT_W'(1)) begin
                found = 1'b1;
                tgt   = cilt_pkg::IDX_W'(j);
            end
        end
    end

    assign stat.full     = (lvl_reg == cilt_pkg::LVL_W'(cilt_pkg::NEST_DEPTH));
    assign stat.top_done = !found;

    always_comb begin
        priority if (cmd.clear) begin
            lvl_next = '0;
        end else if (cmd.push) begin
            lvl_next = lvl_reg + cilt_pkg::LVL_W'(1);
        end else if (cmd.elem_done) begin
            lvl_next = found ? cilt_pkg::LVL_W'(tgt) + cilt_pkg::LVL_W'(1) : '0;
        end else begin
            lvl_next = lvl_reg;
        end
    end

    always_comb begin
        for (int j = 0; j < cilt_pkg::NEST_DEPTH; j++) begin
            rem_next[j] = rem_reg[j];
            if (!cmd.clear && cmd.push && lvl_reg == cilt_pkg::LVL_W'(j)) begin
                rem_next[j] = cmd.push_cnt;
            end else if (!cmd.clear && cmd.elem_done && found &&
                         tgt == cilt_pkg::IDX_W'(j)) begin
                rem_next[j] = rem_reg[j] - cilt_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lvl_reg <= '0;
        end else begin
            lvl_reg <= lvl_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < cilt_pkg::NEST_DEPTH; j++) begin
            rem_reg[j] <= rem_next[j];
        end
    end

    `CILT_ASSERT_ALWAYS(a_lvl_bound, aclk,
        !aresetn || lvl_reg <= cilt_pkg::LVL_W'(cilt_pkg::NEST_DEPTH),
        "stack level beyond nesting depth")
    `CILT_ASSERT(a_push_grows, aclk, aresetn,
        cmd.push && !cmd.clear |=> lvl_reg == $past(lvl_reg) + cilt_pkg::LVL_W'(1),
        "push did not open one level")
    `CILT_ASSERT(a_no_push_full, aclk, aresetn,
        cmd.push |-> !stat.full,
        "push into a full stack")

endmodule

/* hdl/cbor_item_length_tracker.sv */
// Byte-serial tracker for back-to-back top-level CBOR items. One byte enters per
// cycle on the s_ channel and every byte yields exactly one result on the m_
// channel, passing through an input register, then header
// decode plus a flip-flop nesting stack resolved combinationally, then an output
// register. Sustained rate is one byte per cycle; the only stall source is
// backpressure on m_ready. m_item_end marks the last byte of a top-level item
// or a byte that raised an error; m_item_size is the byte count of the item so
// far, saturating; m_status reports unsupported additional info, tags or
// simple/float values, and nesting deeper than the stack. An error clears all
// tracking state, so the next byte is taken as a fresh header.
`include "assert_macros.svh"

module cbor_item_length_tracker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_item_end,
    output logic [15:0] m_item_size,
    output logic [1:0]  m_status
);

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // Tracking state
    cilt_pkg::phase_t            phase_reg, phase_next;
    cilt_pkg::pend_kind_t        pend_reg, pend_next;
    logic [cilt_pkg::SKIP_W-1:0] skip_reg, skip_next;
    logic [cilt_pkg::SIZE_WIDTH-1:0] run_reg, run_next;

    // Output register
    logic                                m_valid_reg;
    logic                                m_end_reg;
    logic [cilt_pkg::ITEM_SIZE_W-1:0]    m_size_reg;
    cilt_pkg::status_t                   m_status_reg;

    cilt_pkg::stk_cmd_t  stk_cmd;
    cilt_pkg::stk_stat_t stk_stat;

    logic advance;

    logic [2:0]                      major;
    logic [4:0]                      ai;
    logic [cilt_pkg::SIZE_WIDTH-1:0] size_inc;
    logic [cilt_pkg::SKIP_W-1:0]     skip_dec;
    logic                            done;
    logic                            open;
    logic [cilt_pkg::CNT_W-1:0]      open_cnt;
    cilt_pkg::status_t               dec_st;
    cilt_pkg::status_t               st;
    logic                            err;
    logic                            item_end;

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign major    = in_byte_reg[7:5];
    assign ai       = in_byte_reg[4:0];
    assign size_inc = (run_reg != cilt_pkg::SIZE_MAX) ?
                      run_reg + cilt_pkg::SIZE_WIDTH'(1) : run_reg;
    assign skip_dec = (skip_reg != '0) ? skip_reg - cilt_pkg::SKIP_W'(1) : skip_reg;

    always_comb begin
        done       = 1'b0;
        open       = 1'b0;
        open_cnt   = '0;
        dec_st     = cilt_pkg::ST_OK;
        phase_next = phase_reg;
        pend_next  = pend_reg;
        skip_next  = skip_reg;
        unique case (phase_reg)
            cilt_pkg::PH_SKIP: begin
                skip_next = skip_dec;
                if (skip_dec == '0) begin
                    done = 1'b1;
                end
            end
            cilt_pkg::PH_LEN: begin
                if (pend_reg == cilt_pkg::PK_STRING) begin
                    if (in_byte_reg == 8'd0) begin
                        done = 1'b1;
                    end else begin
                        skip_next  = in_byte_reg;
                        phase_next = cilt_pkg::PH_SKIP;
                    end
                end else begin
                    open_cnt = (pend_reg == cilt_pkg::PK_MAP) ?
                               {in_byte_reg, 1'b0} : {1'b0, in_byte_reg};
                    if (open_cnt == '0) begin
                        done = 1'b1;
                    end else begin
                        open = 1'b1;
                    end
                end
            end
            cilt_pkg::PH_HEADER: begin
                unique case (major)
                    cilt_pkg::MT_UINT, cilt_pkg::MT_NINT: begin
                        if (ai < cilt_pkg::AI_ONE_BYTE) begin
                            done = 1'b1;
                        end else if (ai <= cilt_pkg::AI_EIGHT_BYTE) begin
                            skip_next  = cilt_pkg::SKIP_W'(1) << ai[1:0];
                            phase_next = cilt_pkg::PH_SKIP;
                        end else begin
                            dec_st = cilt_pkg::ST_ADDL;
                        end
                    end
                    cilt_pkg::MT_BSTR, cilt_pkg::MT_TSTR: begin
                        if (ai < cilt_pkg::AI_ONE_BYTE) begin
                            if (ai == 5'd0) begin
                                done = 1'b1;
                            end else begin
                                skip_next  = cilt_pkg::SKIP_W'(ai);
                                phase_next = cilt_pkg::PH_SKIP;
                            end
                        end else if (ai == cilt_pkg::AI_ONE_BYTE) begin
                            pend_next  = cilt_pkg::PK_STRING;
                            phase_next = cilt_pkg::PH_LEN;
                        end else begin
                            dec_st = cilt_pkg::ST_ADDL;
                        end
                    end
                    cilt_pkg::MT_ARRAY, cilt_pkg::MT_MAP: begin
                        if (ai < cilt_pkg::AI_ONE_BYTE) begin
                            open_cnt = (major == cilt_pkg::MT_MAP) ?
                                       cilt_pkg::CNT_W'({ai, 1'b0}) : cilt_pkg::CNT_W'(ai);
                            if (open_cnt == '0) begin
                                done = 1'b1;
                            end else begin
                                open = 1'b1;
                            end
                        end else if (ai == cilt_pkg::AI_ONE_BYTE) begin
                            pend_next  = (major == cilt_pkg::MT_MAP) ?
                                         cilt_pkg::PK_MAP : cilt_pkg::PK_ARRAY;
                            phase_next = cilt_pkg::PH_LEN;
                        end else begin
                            dec_st = cilt_pkg::ST_ADDL;
                        end
                    end
                    default: begin
                        dec_st = cilt_pkg::ST_TAG;
                    end
                endcase
            end
            default: begin
                phase_next = cilt_pkg::PH_HEADER;
            end
        endcase
        if (done || open) begin
            phase_next = cilt_pkg::PH_HEADER;
        end
    end

    assign st       = (open && stk_stat.full) ? cilt_pkg::ST_DEEP : dec_st;
    assign err      = (st != cilt_pkg::ST_OK);
    assign item_end = err || (done && stk_stat.top_done);
    assign run_next = item_end ? '0 : size_inc;

    assign stk_cmd.elem_done = advance && done && !err;
    assign stk_cmd.push      = advance && open && !err;
    assign stk_cmd.push_cnt  = open_cnt;
    assign stk_cmd.clear     = advance && err;

    cilt_stack u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (stk_cmd),
        .stat    (stk_stat)
    );

    // Control and tracking state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            phase_reg    <= cilt_pkg::PH_HEADER;
            pend_reg     <= cilt_pkg::PK_STRING;
            skip_reg     <= '0;
            run_reg      <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
                if (err) begin
                    phase_reg <= cilt_pkg::PH_HEADER;
                    pend_reg  <= cilt_pkg::PK_STRING;
                    skip_reg  <= '0;
                end else begin
                    phase_reg <= phase_next;
                    pend_reg  <= pend_next;
                    skip_reg  <= skip_next;
                end
                run_reg <= run_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_data_byte;
        end
        if (advance) begin
            m_end_reg    <= item_end;
            m_size_reg   <= cilt_pkg::ITEM_SIZE_W'(size_inc);
            m_status_reg <= st;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_item_end  = m_end_reg;
    assign m_item_size = m_size_reg;
    assign m_status    = m_status_reg;

    `CILT_ASSERT(a_err_ends, aclk, aresetn,
        m_valid && m_status != cilt_pkg::ST_OK |-> m_item_end,
        "error result without item end")
    `CILT_ASSERT(a_err_clears, aclk, aresetn,
        advance && err |=> phase_reg == cilt_pkg::PH_HEADER && run_reg == '0 &&
            skip_reg == '0,
        "state not cleared after error")
    `CILT_ASSERT(a_end_resets_size, aclk, aresetn,
        advance && item_end |=> run_reg == '0,
        "size count kept past item end")

endmodule

/* tb/sv/tb_top.sv */
module tb_top;

    localparam logic [2:0] MT_TAG    = 3'd6;
    localparam logic [2:0] MT_SIMPLE = 3'd7;

    localparam int RAND_BYTES   = 1530;
    localparam int CALM_TAIL    = 250;
    localparam int HOLD_AT      = 700;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 16;

    typedef struct packed {
        logic                             item_end;
        logic [cilt_pkg::ITEM_SIZE_W-1:0] item_size;
        cilt_pkg::status_t                status;
    } tracker_result_t;

    typedef struct {
        logic [7:0]      data;
        bit              typed;
        tracker_result_t want;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        m_valid;
    logic        m_ready;
    logic        m_item_end;
    logic [15:0] m_item_size;
    logic [1:0]  m_status;

    cbor_item_length_tracker u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item_end  (m_item_end),
        .m_item_size (m_item_size),
        .m_status    (m_status)
    );

    always #5 aclk = ~aclk;

    // Shadow of the tracker state
    cilt_pkg::phase_t                trk_phase;
    cilt_pkg::pend_kind_t            trk_kind;
    logic [cilt_pkg::SKIP_W-1:0]     trk_skip;
    logic [cilt_pkg::CNT_W-1:0]      trk_owed [cilt_pkg::NEST_DEPTH];
    int                              trk_level;
    logic [cilt_pkg::SIZE_WIDTH-1:0] trk_size;

    tracker_result_t owed_results[$];
    tracker_result_t head_result;
    dir_row_t        dir_rows[$];
    logic [7:0]      byte_stream[$];

    bit calm;
    int in_count;
    int out_count    = 0;
    int mismatch_cnt = 0;
    int idle_cycles  = 0;
    int tx_idle_pct;
    int rx_idle_pct;
    int status_seen [4] = '{0, 0, 0, 0};

    function automatic logic [7:0] hdr(input logic [2:0] major, input logic [4:0] ai);
        return {major, ai};
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 10;
            default: return 30;
        endcase
    endfunction

    function automatic void clear_tracker();
        trk_phase = cilt_pkg::PH_HEADER;
        trk_kind  = cilt_pkg::PK_STRING;
        trk_skip  = '0;
        foreach (trk_owed[i]) trk_owed[i] = '0;
        trk_level = 0;
        trk_size  = '0;
    endfunction

    // Take one element off the innermost open container, cascading outward.
    // Returns 1 when a top-level item closes.
    function automatic logic close_element();
        trk_phase = cilt_pkg::PH_HEADER;
        while (trk_level > 0) begin
            trk_owed[trk_level-1] = trk_owed[trk_level-1] - 1'b1;
            if (trk_owed[trk_level-1] != 0) return 1'b0;
            trk_level--;
        end
        return 1'b1;
    endfunction

    function automatic cilt_pkg::status_t open_level(input logic [cilt_pkg::CNT_W-1:0] cnt);
        if (trk_level >= cilt_pkg::NEST_DEPTH) return cilt_pkg::ST_DEEP;
        trk_owed[trk_level] = cnt;
        trk_level++;
        trk_phase = cilt_pkg::PH_HEADER;
        return cilt_pkg::ST_OK;
    endfunction

    function automatic tracker_result_t track_byte(input logic [7:0] b);
        tracker_result_t            r;
        logic [2:0]                 major;
        logic [4:0]                 ai;
        logic [cilt_pkg::CNT_W-1:0] cnt;
        cilt_pkg::status_t          st;
        logic                       fin;
        major = b[7:5];
        ai    = b[4:0];
        st    = cilt_pkg::ST_OK;
        fin   = 1'b0;
        if (trk_size != cilt_pkg::SIZE_MAX) trk_size = trk_size + 1'b1;
        r.item_size = cilt_pkg::ITEM_SIZE_W'(trk_size);
        case (trk_phase)
            cilt_pkg::PH_SKIP: begin
                if (trk_skip != 0) trk_skip = trk_skip - 1'b1;
                if (trk_skip == 0) fin = close_element();
            end
            cilt_pkg::PH_LEN: begin
                if (trk_kind == cilt_pkg::PK_STRING) begin
                    if (b == 0) begin
                        fin = close_element();
                    end else begin
                        trk_skip  = b;
                        trk_phase = cilt_pkg::PH_SKIP;
                    end
                end else begin
                    cnt = (trk_kind == cilt_pkg::PK_MAP) ? {b, 1'b0} : {1'b0, b};
                    if (cnt == 0) fin = close_element();
                    else st = open_level(cnt);
                end
            end
            default: begin
                case (major)
                    cilt_pkg::MT_UINT, cilt_pkg::MT_NINT: begin
                        if (ai < cilt_pkg::AI_ONE_BYTE) begin
                            fin = close_element();
                        end else if (ai <= cilt_pkg::AI_EIGHT_BYTE) begin
                            trk_skip  = 8'd1 << (ai - cilt_pkg::AI_ONE_BYTE);
                            trk_phase = cilt_pkg::PH_SKIP;
                        end else begin
                            st = cilt_pkg::ST_ADDL;
                        end
                    end
                    cilt_pkg::MT_BSTR, cilt_pkg::MT_TSTR: begin
                        if (ai < cilt_pkg::AI_ONE_BYTE) begin
                            if (ai == 0) begin
                                fin = close_element();
                            end else begin
                                trk_skip  = cilt_pkg::SKIP_W'(ai);
                                trk_phase = cilt_pkg::PH_SKIP;
                            end
                        end else if (ai == cilt_pkg::AI_ONE_BYTE) begin
                            trk_kind  = cilt_pkg::PK_STRING;
                            trk_phase = cilt_pkg::PH_LEN;
                        end else begin
                            st = cilt_pkg::ST_ADDL;
                        end
                    end
                    cilt_pkg::MT_ARRAY, cilt_pkg::MT_MAP: begin
                        if (ai < cilt_pkg::AI_ONE_BYTE) begin
                            cnt = (major == cilt_pkg::MT_MAP) ? {3'd0, ai, 1'b0} : {4'd0, ai};
                            if (cnt == 0) fin = close_element();
                            else st = open_level(cnt);
                        end else if (ai == cilt_pkg::AI_ONE_BYTE) begin
                            trk_kind  = (major == cilt_pkg::MT_MAP) ?
                                        cilt_pkg::PK_MAP : cilt_pkg::PK_ARRAY;
                            trk_phase = cilt_pkg::PH_LEN;
                        end else begin
                            st = cilt_pkg::ST_ADDL;
                        end
                    end
                    default: st = cilt_pkg::ST_TAG;
                endcase
            end
        endcase
        if (st != cilt_pkg::ST_OK) begin
            fin = 1'b1;
            clear_tracker();
        end else if (fin) begin
            trk_size = '0;
        end
        r.item_end = fin;
        r.status   = st;
        return r;
    endfunction

    function automatic void add_row(input logic [7:0] data, input bit typed, input logic fin,
                                    input int size, input cilt_pkg::status_t st);
        dir_row_t row;
        row.data           = data;
        row.typed          = typed;
        row.want.item_end  = fin;
        row.want.item_size = size[cilt_pkg::ITEM_SIZE_W-1:0];
        row.want.status    = st;
        dir_rows.push_back(row);
    endfunction

    // Append one element's header and payload. Returns how many child elements it opened.
    function automatic int add_element(input bit may_open);
        int         pick;
        int         n;
        int         len;
        logic [2:0] major;
        logic [4:0] ai;
        pick = $urandom_range(0, 9);
        if (may_open && pick >= 8) begin
            major = $urandom_range(0, 1) ? cilt_pkg::MT_MAP : cilt_pkg::MT_ARRAY;
            n = $urandom_range(0, 4);
            if ($urandom_range(0, 3) == 0) begin
                byte_stream.push_back(hdr(major, cilt_pkg::AI_ONE_BYTE));
                byte_stream.push_back(8'(n));
            end else begin
                byte_stream.push_back(hdr(major, 5'(n)));
            end
            return (major == cilt_pkg::MT_MAP) ? 2 * n : n;
        end
        if (pick < 4) begin
            major = $urandom_range(0, 1) ? cilt_pkg::MT_NINT : cilt_pkg::MT_UINT;
            ai = 5'($urandom_range(0, 27));
            byte_stream.push_back(hdr(major, ai));
            if (ai >= cilt_pkg::AI_ONE_BYTE)
                repeat (1 << (ai - cilt_pkg::AI_ONE_BYTE)) byte_stream.push_back(8'($urandom));
        end else begin
            major = $urandom_range(0, 1) ? cilt_pkg::MT_TSTR : cilt_pkg::MT_BSTR;
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 40);
            if (len < 24 && $urandom_range(0, 1)) begin
                byte_stream.push_back(hdr(major, 5'(len)));
            end else begin
                byte_stream.push_back(hdr(major, cilt_pkg::AI_ONE_BYTE));
                byte_stream.push_back(8'(len));
            end
            repeat (len) byte_stream.push_back(8'($urandom));
        end
        return 0;
    endfunction

    function automatic void add_well_formed();
        int owed[$];
        int opened;
        do begin
            opened = add_element(owed.size() < cilt_pkg::NEST_DEPTH);
            if (opened > 0) begin
                owed.push_back(opened);
            end else begin
                while (owed.size() > 0 && owed[$] == 1) void'(owed.pop_back());
                if (owed.size() > 0) owed[$] = owed[$] - 1;
            end
        end while (owed.size() > 0);
    endfunction

    task automatic flag_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatch_cnt++;
        $display("mismatch on result %0d: %s got %0h, expected %0h",
                 out_count, field, got, want);
    endtask

    // Hold payload until the transfer, then update the shadow state.
    task automatic send_byte(input logic [7:0] b, input bit typed, input tracker_result_t want);
        tracker_result_t got;
        if (!calm && $urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        do @(posedge aclk); while (!s_ready);
        got = track_byte(b);
        owed_results.push_back(typed ? want : got);
        in_count++;
        @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            out_count++;
            if (owed_results.size() == 0) begin
                flag_mismatch("result with nothing pending, item_size",
                              32'(m_item_size), 32'd0);
            end else begin
                head_result = owed_results.pop_front();
                if (m_item_end !== head_result.item_end)
                    flag_mismatch("item_end", 32'(m_item_end), 32'(head_result.item_end));
                if (m_item_size !== head_result.item_size)
                    flag_mismatch("item_size", 32'(m_item_size), 32'(head_result.item_size));
                if (m_status !== head_result.status)
                    flag_mismatch("status", 32'(m_status), 32'(head_result.status));
            end
            if (m_item_end === 1'b1) status_seen[m_status]++;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("[cbor_item_length_tracker] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: random backpressure, plus one long hold-off to fill the block
    initial begin
        int  rx_ticks;
        bit  hold_done;
        rx_ticks  = 0;
        hold_done = 1'b0;
        rx_idle_pct = pick_idle_pct();
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            rx_ticks++;
            if (rx_ticks % 200 == 0) rx_idle_pct = pick_idle_pct();
            if (!hold_done && in_count >= HOLD_AT) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else if (!calm && $urandom_range(0, 99) < rx_idle_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 14) - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        int  start;
        int  mode;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data_byte  = 8'd0;
        calm         = 1'b0;
        in_count     = 0;
        tx_idle_pct  = pick_idle_pct();
        clear_tracker();

        //      byte                                        typed end   size status
        add_row(hdr(cilt_pkg::MT_UINT, 5'd0),               1'b1, 1'b1, 1, cilt_pkg::ST_OK);
        add_row(hdr(cilt_pkg::MT_NINT, 5'd23),              1'b1, 1'b1, 1, cilt_pkg::ST_OK);
        add_row(hdr(cilt_pkg::MT_UINT, 5'd28),              1'b1, 1'b1, 1, cilt_pkg::ST_ADDL);
        add_row(hdr(cilt_pkg::MT_NINT, 5'd31),              1'b1, 1'b1, 1, cilt_pkg::ST_ADDL);
        add_row(hdr(MT_TAG, 5'd0),                          1'b1, 1'b1, 1, cilt_pkg::ST_TAG);
        add_row(hdr(MT_SIMPLE, 5'd31),                      1'b1, 1'b1, 1, cilt_pkg::ST_TAG);
        add_row(hdr(cilt_pkg::MT_BSTR, 5'd0),               1'b1, 1'b1, 1, cilt_pkg::ST_OK);
        add_row(hdr(cilt_pkg::MT_MAP, 5'd0),                1'b1, 1'b1, 1, cilt_pkg::ST_OK);
        add_row(hdr(cilt_pkg::MT_ARRAY, 5'd31),             1'b1, 1'b1, 1, cilt_pkg::ST_ADDL);
        add_row(hdr(cilt_pkg::MT_BSTR, 5'd25),              1'b1, 1'b1, 1, cilt_pkg::ST_ADDL);
        add_row(hdr(cilt_pkg::MT_TSTR, cilt_pkg::AI_ONE_BYTE), 1'b0, 1'b0, 0, cilt_pkg::ST_OK);
        add_row(8'h00,                                      1'b0, 1'b0, 0, cilt_pkg::ST_OK);
        repeat (cilt_pkg::NEST_DEPTH)
            add_row(hdr(cilt_pkg::MT_ARRAY, 5'd1),          1'b0, 1'b0, 0, cilt_pkg::ST_OK);
        add_row(hdr(cilt_pkg::MT_ARRAY, 5'd1),              1'b1, 1'b1,
                cilt_pkg::NEST_DEPTH + 1, cilt_pkg::ST_DEEP);
        add_row(hdr(cilt_pkg::MT_UINT, cilt_pkg::AI_ONE_BYTE), 1'b0, 1'b0, 0, cilt_pkg::ST_OK);
        add_row(8'hFF,                                      1'b0, 1'b0, 0, cilt_pkg::ST_OK);

        while (byte_stream.size() < RAND_BYTES) begin
            start = byte_stream.size();
            mode  = $urandom_range(0, 19);
            if (mode < 14) begin
                add_well_formed();
            end else if (mode < 16) begin
                // corrupt one byte of an otherwise clean item
                add_well_formed();
                byte_stream[$urandom_range(start, byte_stream.size() - 1)] = 8'($urandom);
            end else if (mode < 17) begin
                // nest right up to the stack limit, or one past it
                repeat (cilt_pkg::NEST_DEPTH + $urandom_range(0, 1))
                    byte_stream.push_back(hdr(cilt_pkg::MT_ARRAY, 5'd1));
                void'(add_element(1'b0));
            end else begin
                repeat ($urandom_range(1, 4)) byte_stream.push_back(8'($urandom));
            end
        end

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) send_byte(dir_rows[i].data, dir_rows[i].typed, dir_rows[i].want);
        foreach (byte_stream[k]) begin
            if (k % 128 == 0) tx_idle_pct = pick_idle_pct();
            calm = (k >= byte_stream.size() - CALM_TAIL);
            send_byte(byte_stream[k], 1'b0, '0);
        end
        s_valid <= 1'b0;

        while (owed_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run covered %0d bytes and %0d results; %0d items closed cleanly",
                 in_count, out_count, status_seen[cilt_pkg::ST_OK]);
        $display("error endings addl/tag/deep: %0d/%0d/%0d",
                 status_seen[cilt_pkg::ST_ADDL], status_seen[cilt_pkg::ST_TAG],
                 status_seen[cilt_pkg::ST_DEEP]);
        if (mismatch_cnt == 0) begin
            $display("[cbor_item_length_tracker] OK");
        end else begin
            $display("[cbor_item_length_tracker] ERROR");
        end
        $finish;
    end

endmodule

/* cbor_item_length_tracker.f */
+incdir+hdl
hdl/cilt_pkg.sv
hdl/cilt_stack.sv
hdl/cbor_item_length_tracker.sv
tb/sv/tb_top.sv
